>>> rtl/core/hough_circle_gradient_voter_macros.svh
// Assertion macros used by the voter checker.
`ifndef HOUGH_CIRCLE_GRADIENT_VOTER_MACROS_SVH
`define HOUGH_CIRCLE_GRADIENT_VOTER_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define HCGV_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hcgv: assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define HCGV_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hcgv: assertion failed");

`endif

>>> rtl/core/hcgv_pkg.sv
// Shared types and constants of the Hough circle gradient voter.
package hcgv_pkg;

   localparam logic [1:0] CMD_VOTE  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [2:0] REG_GRID_COLS  = 3'd0;
   localparam logic [2:0] REG_GRID_ROWS  = 3'd1;
   localparam logic [2:0] REG_RADIUS_MIN = 3'd2;
   localparam logic [2:0] REG_RADIUS_MAX = 3'd3;
   localparam logic [2:0] REG_INV_SCALE  = 3'd4;
   localparam logic [2:0] REG_PEAK_THR   = 3'd5;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;
   localparam logic [10:0] Q10_ONE = 11'd1024;

   typedef struct packed {
      logic [8:0]  grid_cols;
      logic [8:0]  grid_rows;
      logic [9:0]  radius_min;
      logic [9:0]  radius_max;
      logic [10:0] inv_scale_q10;
      logic [15:0] peak_threshold;
   } cfg_type;

   typedef struct packed {
      logic [9:0]        pixel_x;
      logic [9:0]        pixel_y;
      logic              is_edge;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic [7:0]        cell_col;
      logic [7:0]        cell_row;
   } req_type;

   typedef struct packed {
      logic capture;
      logic sq;
      logic sum;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic axis;
      logic walk_init;
      logic walk_flip;
      logic rmw_read;
      logic rmw_write;
      logic rd_center;
      logic rd_first_nb;
      logic rd_next_nb;
      logic clr_start;
      logic clr_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic skip;
      logic sqrt_last;
      logic div_last;
      logic walk_end;
      logic in_grid;
      logic interior;
      logic nb_last;
      logic clr_last;
   } dp_sts_type;

endpackage

>>> rtl/core/hcgv_datapath.sv
// Datapath: gradient normalization, walk arithmetic and the vote store.
module hcgv_datapath #(
   parameter int GRID_W     = 256,
   parameter int GRID_H     = 256,
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hcgv_pkg::cfg_type    cfg,
   input  hcgv_pkg::req_type    req,
   input  hcgv_pkg::dp_cmd_type cmd,
   output hcgv_pkg::dp_sts_type sts,
   output logic [11:0]          votes_cast,
   output logic [15:0]          cell_count,
   output logic                 is_peak
);
   import hcgv_pkg::*;

   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int QB    = FRAC_BITS + 2;
   localparam int NW    = FRAC_BITS + 28;
   localparam int SW    = QB + 1;
   localparam int PW    = FRAC_BITS + 13;
   localparam int XW    = FRAC_BITS + 11;
   localparam int DCW   = $clog2(QB);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] store_mem [DEPTH];

   req_type               req_ff;
   logic [31:0]           sqx_ff, sqy_ff, sum_ff, root_ff, bit_ff;
   logic [XW-1:0]         x0_ff, y0_ff;
   logic [NW-1:0]         rem_ff, dv_ff;
   logic [QB-1:0]         q_ff;
   logic [DCW-1:0]        dcnt_ff;
   logic signed [SW-1:0]  step_x_ff, step_y_ff;
   logic signed [PW-1:0]  pos_x_ff, pos_y_ff;
   logic [10:0]           cnt_ff;
   logic [AW-1:0]         addr_ff, clr_ff;
   logic [COUNT_BITS-1:0] rd_ff, center_ff;
   logic [1:0]            nb_ff;
   logic [11:0]           cast_ff;
   logic [15:0]           count_ff;
   logic                  peak_ff;

   logic [10:0]           inv_eff, cols_eff, rows_eff;
   logic [15:0]           ax, ay, a_sel;
   logic [26:0]           a_prod;
   logic [20:0]           px_prod, py_prod;
   logic [20+FRAC_BITS:0] xs, ys;
   logic [31:0]           root_try;
   logic [QB-1:0]         q_next;
   logic                  g_neg;
   logic signed [SW-1:0]  step_val;
   logic signed [SW+10:0] mx, my;
   logic [11:0]           cx, cy;
   logic [AW-1:0]         walk_addr, ctr_addr, nb_addr;
   logic [1:0]            nb_sel;
   logic [31:0]           rd_wide, thr_wide;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [COUNT_BITS-1:0] mem_wd;

   assign inv_eff  = (cfg.inv_scale_q10 > Q10_ONE) ? Q10_ONE : cfg.inv_scale_q10;
   assign cols_eff = ({2'b0, cfg.grid_cols} < 11'(GRID_W)) ? {2'b0, cfg.grid_cols} : 11'(GRID_W);
   assign rows_eff = ({2'b0, cfg.grid_rows} < 11'(GRID_H)) ? {2'b0, cfg.grid_rows} : 11'(GRID_H);

   assign ax = req_ff.grad_x[15] ? 16'(-req_ff.grad_x) : req_ff.grad_x;
   assign ay = req_ff.grad_y[15] ? 16'(-req_ff.grad_y) : req_ff.grad_y;

   assign px_prod = req_ff.pixel_x * inv_eff;
   assign py_prod = req_ff.pixel_y * inv_eff;
   assign xs = {px_prod, {FRAC_BITS{1'b0}}} + (21 + FRAC_BITS)'(512);
   assign ys = {py_prod, {FRAC_BITS{1'b0}}} + (21 + FRAC_BITS)'(512);

   assign root_try = root_ff + bit_ff;

   assign a_sel  = cmd.axis ? ay : ax;
   assign g_neg  = cmd.axis ? req_ff.grad_y[15] : req_ff.grad_x[15];
   assign a_prod = a_sel * inv_eff;
   assign q_next = (rem_ff >= dv_ff) ? {q_ff[QB-2:0], 1'b1} : {q_ff[QB-2:0], 1'b0};
   assign step_val = g_neg ? -SW'(q_next) : SW'(q_next);

   assign mx = $signed({1'b0, cfg.radius_min}) * step_x_ff;
   assign my = $signed({1'b0, cfg.radius_min}) * step_y_ff;

   assign cx = pos_x_ff[PW-2:FRAC_BITS];
   assign cy = pos_y_ff[PW-2:FRAC_BITS];
   assign walk_addr = AW'(cy * GRID_W + cx);
   assign ctr_addr  = AW'(req_ff.cell_row * GRID_W + req_ff.cell_col);

   assign nb_sel = cmd.rd_first_nb ? 2'd0 : nb_ff + 2'd1;
   always_comb begin
      case (nb_sel)
         2'd0:    nb_addr = addr_ff - AW'(1);
         2'd1:    nb_addr = addr_ff + AW'(1);
         2'd2:    nb_addr = addr_ff - AW'(GRID_W);
         default: nb_addr = addr_ff + AW'(GRID_W);
      endcase
   end

   assign rd_wide  = 32'(rd_ff);
   assign thr_wide = 32'(cfg.peak_threshold);

   assign sts.skip      = !req_ff.is_edge || (req_ff.grad_x == 16'sd0 && req_ff.grad_y == 16'sd0)
                          || (cfg.radius_max < cfg.radius_min);
   assign sts.sqrt_last = bit_ff[0];
   assign sts.div_last  = (dcnt_ff == DCW'(QB - 1));
   assign sts.walk_end  = pos_x_ff[PW-1] || pos_y_ff[PW-1] || (cx >= 12'(cols_eff))
                          || (cy >= 12'(rows_eff)) || (cnt_ff == 11'd0);
   assign sts.in_grid   = ({3'b0, req_ff.cell_col} < cols_eff) && ({3'b0, req_ff.cell_row} < rows_eff);
   assign sts.interior  = (req_ff.cell_col != 8'd0) && (req_ff.cell_row != 8'd0)
                          && (11'(req_ff.cell_col) + 11'd1 < cols_eff)
                          && (11'(req_ff.cell_row) + 11'd1 < rows_eff);
   assign sts.nb_last   = (nb_ff == 2'd3);
   assign sts.clr_last  = (clr_ff == AW'(DEPTH - 1));

   always_comb begin
      mem_we = cmd.clr_step || cmd.rmw_write;
      mem_wa = cmd.clr_step ? clr_ff : addr_ff;
      mem_wd = cmd.clr_step ? '0 : ((rd_ff == CMAX) ? rd_ff : rd_ff + COUNT_BITS'(1));
      mem_re = cmd.rmw_read || cmd.rd_center || cmd.rd_first_nb || cmd.rd_next_nb;
      mem_ra = cmd.rmw_read ? walk_addr : (cmd.rd_center ? ctr_addr : nb_addr);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= store_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_start) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req;
         cast_ff  <= '0;
         count_ff <= '0;
         peak_ff  <= 1'b0;
      end
      if (cmd.sq) begin
         sqx_ff <= ax * ax;
         sqy_ff <= ay * ay;
         x0_ff  <= xs[20+FRAC_BITS:10];
         y0_ff  <= ys[20+FRAC_BITS:10];
      end
      if (cmd.sum) begin
         sum_ff  <= sqx_ff + sqy_ff;
         root_ff <= '0;
         bit_ff  <= 32'h4000_0000;
      end
      if (cmd.sqrt_step) begin
         if (sum_ff >= root_try) begin
            sum_ff  <= sum_ff - root_try;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         rem_ff  <= (NW'(a_prod) << (FRAC_BITS + 1)) + (NW'(root_ff[15:0]) << 10);
         dv_ff   <= NW'(root_ff[15:0]) << (10 + QB);
         q_ff    <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dv_ff) begin
            rem_ff <= rem_ff - dv_ff;
         end
         q_ff    <= q_next;
         dv_ff   <= dv_ff >> 1;
         dcnt_ff <= dcnt_ff + DCW'(1);
         if (sts.div_last) begin
            if (cmd.axis) begin
               step_y_ff <= step_val;
            end else begin
               step_x_ff <= step_val;
            end
         end
      end
      if (cmd.walk_flip) begin
         step_x_ff <= -step_x_ff;
         step_y_ff <= -step_y_ff;
      end
      if (cmd.walk_init) begin
         pos_x_ff <= PW'($signed({1'b0, x0_ff})) + PW'(mx);
         pos_y_ff <= PW'($signed({1'b0, y0_ff})) + PW'(my);
         cnt_ff   <= {1'b0, cfg.radius_max} - {1'b0, cfg.radius_min} + 11'd1;
      end
      if (cmd.rmw_read) begin
         addr_ff <= walk_addr;
      end
      if (cmd.rmw_write) begin
         cast_ff  <= cast_ff + 12'd1;
         pos_x_ff <= pos_x_ff + PW'(step_x_ff);
         pos_y_ff <= pos_y_ff + PW'(step_y_ff);
         cnt_ff   <= cnt_ff - 11'd1;
      end
      if (cmd.rd_center) begin
         addr_ff <= ctr_addr;
      end
      if (cmd.rd_first_nb) begin
         center_ff <= rd_ff;
         count_ff  <= (rd_wide > 32'h0000_FFFF) ? 16'hFFFF : rd_wide[15:0];
         peak_ff   <= sts.interior && (rd_wide > thr_wide);
         nb_ff     <= 2'd0;
      end
      if (cmd.rd_next_nb) begin
         peak_ff <= peak_ff && (center_ff > rd_ff);
         nb_ff   <= nb_ff + 2'd1;
      end
   end

   assign votes_cast = cast_ff;
   assign cell_count = count_ff;
   assign is_peak    = peak_ff;

endmodule

>>> rtl/core/hcgv_ctrl.sv
// Controller state machine sequencing vote, read and clear requests.
module hcgv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_cmd,
   input  logic                 rsp_busy,
   input  hcgv_pkg::dp_sts_type sts,
   output logic                 req_tready,
   output hcgv_pkg::dp_cmd_type cmd
);
   import hcgv_pkg::*;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_DINIT = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_WINIT = 4'd7;
   localparam logic [3:0] S_WADDR = 4'd8;
   localparam logic [3:0] S_WWR   = 4'd9;
   localparam logic [3:0] S_RCHK  = 4'd10;
   localparam logic [3:0] S_RCTR  = 4'd11;
   localparam logic [3:0] S_RNB   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       axis_ff, axis_in;
   logic       dir_ff, dir_in;
   logic       clrcmd_ff, clrcmd_in;

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      dir_in     = dir_ff;
      clrcmd_in  = clrcmd_ff;
      cmd        = '0;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in  = clrcmd_ff ? S_DONE : S_IDLE;
               clrcmd_in = 1'b0;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (req_cmd)
                  CMD_VOTE:  state_in = S_SQ;
                  CMD_READ:  state_in = S_RCHK;
                  CMD_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     clrcmd_in     = 1'b1;
                     state_in      = S_CLR;
                  end
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = sts.skip ? S_DONE : S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_last) begin
               axis_in  = 1'b0;
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = S_DINIT;
               end else begin
                  dir_in   = 1'b0;
                  state_in = S_WINIT;
               end
            end
         end
         S_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WADDR;
         end
         S_WADDR: begin
            if (sts.walk_end) begin
               if (!dir_ff) begin
                  cmd.walk_flip = 1'b1;
                  dir_in        = 1'b1;
                  state_in      = S_WINIT;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.rmw_read = 1'b1;
               state_in     = S_WWR;
            end
         end
         S_WWR: begin
            cmd.rmw_write = 1'b1;
            state_in      = S_WADDR;
         end
         S_RCHK: begin
            if (sts.in_grid) begin
               cmd.rd_center = 1'b1;
               state_in      = S_RCTR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RCTR: begin
            cmd.rd_first_nb = 1'b1;
            state_in        = sts.interior ? S_RNB : S_DONE;
         end
         S_RNB: begin
            cmd.rd_next_nb = 1'b1;
            if (sts.nb_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         axis_ff   <= 1'b0;
         dir_ff    <= 1'b0;
         clrcmd_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         dir_ff    <= dir_in;
         clrcmd_ff <= clrcmd_in;
      end
   end

endmodule

>>> rtl/core/hough_circle_gradient_voter.sv
// Top level of the Hough circle gradient voter: ports, registers, result buffer.
//
//   channel  direction  payload
//   req      in         tuser: cmd; tdata: pixel, gradient, cell address
//   rsp      out        tdata: votes_cast, cell_count, is_peak
//   csr      in         index 0..5 and 16-bit write data
//
// One request at a time. A vote runs the 16-step square root, a 12-step divide for
// each axis at FRAC_BITS = 10, and a read then write of the vote store for each
// cell. A read does up to six store reads; a clear zeroes the whole store.
// After reset the store is zeroed with req_tready low.
// A held response does not stop the next request from starting.
module hough_circle_gradient_voter #(
   parameter int GRID_W     = 256,
   parameter int GRID_H     = 256,
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pixel_x, pixel_y, is_edge, grad_x, grad_y, cell_col, cell_row, zero fill
   input  logic [hcgv_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // votes_cast, cell_count, is_peak, zero fill
   output logic [hcgv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [15:0]                     csr_data
);
   import hcgv_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   req_type                 req;
   dp_cmd_type              cmd;
   dp_sts_type              sts;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   logic [11:0]             votes_cast;
   logic [15:0]             cell_count;
   logic                    is_peak;
   logic                    rsp_busy;

   assign req.pixel_x  = req_tdata[9:0];
   assign req.pixel_y  = req_tdata[19:10];
   assign req.is_edge  = req_tdata[20];
   assign req.grad_x   = req_tdata[36:21];
   assign req.grad_y   = req_tdata[52:37];
   assign req.cell_col = req_tdata[60:53];
   assign req.cell_row = req_tdata[68:61];

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_COLS:  cfg_in.grid_cols      = csr_data[8:0];
            REG_GRID_ROWS:  cfg_in.grid_rows      = csr_data[8:0];
            REG_RADIUS_MIN: cfg_in.radius_min     = csr_data[9:0];
            REG_RADIUS_MAX: cfg_in.radius_max     = csr_data[9:0];
            REG_INV_SCALE:  cfg_in.inv_scale_q10  = csr_data[10:0];
            REG_PEAK_THR:   cfg_in.peak_threshold = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_cols      <= 9'd256;
         cfg_ff.grid_rows      <= 9'd256;
         cfg_ff.radius_min     <= 10'd10;
         cfg_ff.radius_max     <= 10'd100;
         cfg_ff.inv_scale_q10  <= 11'd1024;
         cfg_ff.peak_threshold <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign rsp_busy      = rsp_tvalid_ff && !rsp_tready;
   assign rsp_tvalid_in = cmd.emit || rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata_ff <= {3'b000, is_peak, cell_count, votes_cast};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   hcgv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .rsp_busy   (rsp_busy),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   hcgv_datapath #(
      .GRID_W     (GRID_W),
      .GRID_H     (GRID_H),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .cmd        (cmd),
      .sts        (sts),
      .votes_cast (votes_cast),
      .cell_count (cell_count),
      .is_peak    (is_peak)
   );

endmodule

>>> rtl/core/hcgv_checker.sv
// Port-level checker for the voter, bound to the top level.
`include "hough_circle_gradient_voter_macros.svh"

module hcgv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   `HCGV_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `HCGV_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)
   `HCGV_ASSERT_IMPL(a_fields_exclusive, rsp_tvalid && (rsp_tdata[11:0] != 12'd0), rsp_tdata[28:12] == 17'd0)
   `HCGV_ASSERT_IMPL(a_peak_nonzero, rsp_tvalid && rsp_tdata[28], rsp_tdata[27:12] != 16'd0)

endmodule

bind hough_circle_gradient_voter hcgv_checker u_chk (.*);

>>> sim/tb_hough_circle_gradient_voter.sv
// Self-checking testbench for the Hough circle gradient voter: directed and random requests.
module tb_hough_circle_gradient_voter;
   import hcgv_pkg::*;

   localparam int LIMIT_CYCLES = 4000000;

   typedef struct {
      logic [11:0] votes_cast;
      logic [15:0] cell_count;
      logic        is_peak;
   } rsp_fields_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = CMD_NOP;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   cfg_type model_cfg;
   int unsigned vote_counts [65536];
   rsp_fields_type pending_rsp [$];
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int cycle_count = 0;

   hough_circle_gradient_voter dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (cycle_count > LIMIT_CYCLES) begin
         $display("hough_circle_gradient_voter regression: fail");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   function automatic longint unit_step(input longint g, input longint unsigned mag,
                                        input longint unsigned inv);
      longint unsigned a, num, den, q;
      a = (g < 0) ? -g : g;
      num = (a * inv) << 10;
      den = mag << 10;
      q = (2 * num + den) / (2 * den);
      return (g < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic int unsigned cast_votes(input req_type r);
      longint gx, gy, sx, sy, x0, y0, x1, y1;
      longint unsigned inv, mag, cols, rows;
      int unsigned cast;
      int rad;
      cast = 0;
      gx = r.grad_x;
      gy = r.grad_y;
      inv = (model_cfg.inv_scale_q10 > 1024) ? 1024 : model_cfg.inv_scale_q10;
      cols = (model_cfg.grid_cols < 256) ? model_cfg.grid_cols : 256;
      rows = (model_cfg.grid_rows < 256) ? model_cfg.grid_rows : 256;
      if (!r.is_edge || (gx == 0 && gy == 0)) return 0;
      if (model_cfg.radius_max < model_cfg.radius_min) return 0;
      mag = int_sqrt(gx * gx + gy * gy);
      sx = unit_step(gx, mag, inv);
      sy = unit_step(gy, mag, inv);
      x0 = (((longint'(r.pixel_x) * inv) << 10) + 512) >> 10;
      y0 = (((longint'(r.pixel_y) * inv) << 10) + 512) >> 10;
      for (int dir = 0; dir < 2; dir++) begin
         x1 = x0 + longint'(model_cfg.radius_min) * sx;
         y1 = y0 + longint'(model_cfg.radius_min) * sy;
         for (rad = model_cfg.radius_min; rad <= model_cfg.radius_max; rad++) begin
            if (x1 < 0 || y1 < 0) break;
            if ((x1 >> 10) >= cols || (y1 >> 10) >= rows) break;
            if (vote_counts[(y1 >> 10) * 256 + (x1 >> 10)] < 65535)
               vote_counts[(y1 >> 10) * 256 + (x1 >> 10)]++;
            cast++;
            x1 += sx;
            y1 += sy;
         end
         sx = -sx;
         sy = -sy;
      end
      return cast;
   endfunction

   function automatic void predict_response(input logic [1:0] cmd, input req_type r);
      rsp_fields_type e;
      int unsigned c, w, cols, rows, v;
      e.votes_cast = '0;
      e.cell_count = '0;
      e.is_peak = 1'b0;
      cols = (model_cfg.grid_cols < 256) ? model_cfg.grid_cols : 256;
      rows = (model_cfg.grid_rows < 256) ? model_cfg.grid_rows : 256;
      case (cmd)
         CMD_VOTE: e.votes_cast = 12'(cast_votes(r));
         CMD_READ: begin
            c = r.cell_col;
            w = r.cell_row;
            if (c < cols && w < rows) begin
               v = vote_counts[w * 256 + c];
               e.cell_count = 16'(v);
               e.is_peak = c >= 1 && w >= 1 && c + 1 < cols && w + 1 < rows &&
                  v > model_cfg.peak_threshold &&
                  v > vote_counts[w * 256 + c - 1] && v > vote_counts[w * 256 + c + 1] &&
                  v > vote_counts[(w - 1) * 256 + c] && v > vote_counts[(w + 1) * 256 + c];
            end
         end
         CMD_CLEAR: foreach (vote_counts[i]) vote_counts[i] = 0;
         default: ;
      endcase
      pending_rsp = {pending_rsp, e};
   endfunction

   // ---------------- response check ----------------
   always @(negedge clock) begin
      rsp_fields_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tdata[11:0] !== e.votes_cast || rsp_tdata[27:12] !== e.cell_count ||
                rsp_tdata[28] !== e.is_peak) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: exp votes %0d count %0d peak %0d, got %h",
                           e.votes_cast, e.cell_count, e.is_peak, rsp_tdata);
            end
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic send_request(input logic [1:0] cmd, input req_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b000, r.cell_row, r.cell_col, r.grad_y, r.grad_x, r.is_edge,
                    r.pixel_y, r.pixel_x};
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
      predict_response(cmd, r);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      case (index)
         REG_GRID_COLS:  model_cfg.grid_cols = value[8:0];
         REG_GRID_ROWS:  model_cfg.grid_rows = value[8:0];
         REG_RADIUS_MIN: model_cfg.radius_min = value[9:0];
         REG_RADIUS_MAX: model_cfg.radius_max = value[9:0];
         REG_INV_SCALE:  model_cfg.inv_scale_q10 = value[10:0];
         REG_PEAK_THR:   model_cfg.peak_threshold = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input int cols, input int rows, input int rmin, input int rmax,
                             input int inv, input int thr);
      drain_responses();
      write_csr(REG_GRID_COLS, 16'(cols));
      write_csr(REG_GRID_ROWS, 16'(rows));
      write_csr(REG_RADIUS_MIN, 16'(rmin));
      write_csr(REG_RADIUS_MAX, 16'(rmax));
      write_csr(REG_INV_SCALE, 16'(inv));
      write_csr(REG_PEAK_THR, 16'(thr));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_pixel(input int px, input int py, input bit edge_flag,
                                          input int gx, input int gy);
      req_type r;
      r = '0;
      r.pixel_x = 10'(px);
      r.pixel_y = 10'(py);
      r.is_edge = edge_flag;
      r.grad_x = 16'(gx);
      r.grad_y = 16'(gy);
      return r;
   endfunction

   function automatic req_type make_cell(input int c, input int w);
      req_type r;
      r = '0;
      r.cell_col = 8'(c);
      r.cell_row = 8'(w);
      return r;
   endfunction

   function automatic req_type random_request(input logic [1:0] cmd);
      req_type r;
      int unsigned span_x, span_y, inv;
      r = req_type'({$urandom, $urandom, $urandom});
      inv = (model_cfg.inv_scale_q10 == 0) ? 1 : model_cfg.inv_scale_q10;
      span_x = model_cfg.grid_cols * 1024 / inv;
      span_y = model_cfg.grid_rows * 1024 / inv;
      if ($urandom_range(9) != 0) begin
         r.pixel_x = 10'($urandom_range(span_x > 1023 ? 1023 : span_x));
         r.pixel_y = 10'($urandom_range(span_y > 1023 ? 1023 : span_y));
         r.is_edge = ($urandom_range(9) != 0);
         if ($urandom_range(1)) begin
            r.grad_x = 16'($signed($urandom_range(400)) - 200);
            r.grad_y = 16'($signed($urandom_range(400)) - 200);
         end
      end
      if (cmd == CMD_READ && $urandom_range(9) != 0) begin
         r.cell_col = 8'($urandom_range(model_cfg.grid_cols > 255 ? 255 : model_cfg.grid_cols));
         r.cell_row = 8'($urandom_range(model_cfg.grid_rows > 255 ? 255 : model_cfg.grid_rows));
      end
      return r;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      send_request(CMD_VOTE, make_pixel(128, 128, 1, 100, 0));
      send_request(CMD_READ, make_cell(138, 128));
      send_request(CMD_VOTE, make_pixel(128, 128, 0, 100, 0));
      send_request(CMD_VOTE, make_pixel(128, 128, 1, 0, 0));
      send_request(CMD_VOTE, make_pixel(1023, 1023, 1, -32768, 32767));
      send_request(CMD_VOTE, make_pixel(0, 0, 1, 32767, -32768));
      send_request(CMD_VOTE, make_pixel(0, 1023, 1, -1, -1));
      send_request(CMD_READ, make_cell(255, 255));
      send_request(CMD_READ, make_cell(0, 0));
      send_request(CMD_NOP, make_cell(5, 5));
      send_request(CMD_CLEAR, '0);
      send_request(CMD_READ, make_cell(138, 128));
      set_config(10, 12, 50, 40, 1024, 0);
      send_request(CMD_VOTE, make_pixel(5, 5, 1, 3, 4));
      set_config(10, 12, 0, 3, 0, 0);
      send_request(CMD_VOTE, make_pixel(700, 300, 1, 3, 4));
      send_request(CMD_READ, make_cell(0, 0));
      send_request(CMD_READ, make_cell(10, 3));
      send_request(CMD_READ, make_cell(3, 12));
      set_config(9, 9, 0, 2, 1024, 0);
      send_request(CMD_VOTE, make_pixel(4, 4, 1, 10, 0));
      send_request(CMD_VOTE, make_pixel(4, 4, 1, 0, 10));
      send_request(CMD_READ, make_cell(4, 4));
      send_request(CMD_READ, make_cell(0, 4));
   endtask

   task automatic test_saturation();
      set_config(3, 3, 0, 1023, 1, 0);
      for (int i = 0; i < 34; i++) send_request(CMD_VOTE, make_pixel(512, 512, 1, 5, 0));
      send_request(CMD_READ, make_cell(0, 0));
      send_request(CMD_READ, make_cell(1, 0));
      set_config(3, 3, 0, 1023, 2047, 65535);
      send_request(CMD_VOTE, make_pixel(1, 1, 1, 1, 1));
      send_request(CMD_READ, make_cell(1, 1));
      send_request(CMD_CLEAR, '0);
   endtask

   task automatic test_config_extremes();
      int settings [6][6] = '{'{3, 3, 0, 0, 1024, 0}, '{256, 256, 0, 1023, 1024, 65535},
                              '{256, 3, 1023, 1023, 512, 1}, '{3, 256, 0, 5, 1, 0},
                              '{17, 40, 2, 9, 700, 2}, '{256, 256, 10, 100, 1024, 100}};
      for (int s = 0; s < 6; s++) begin
         set_config(settings[s][0], settings[s][1], settings[s][2], settings[s][3],
                    settings[s][4], settings[s][5]);
         for (int i = 0; i < 6; i++)
            send_request(i % 3 == 2 ? CMD_READ : CMD_VOTE,
                         random_request(i % 3 == 2 ? CMD_READ : CMD_VOTE));
      end
   endtask

   task automatic test_random(input int idle, input int stall, input int count);
      int rmin, pick, clears;
      logic [1:0] cmd;
      clears = 0;
      sender_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            rmin = $urandom_range(8);
            set_config($urandom_range(3, 40), $urandom_range(3, 40), rmin,
                       rmin + $urandom_range(20) - 2, $urandom_range(128, 1024),
                       $urandom_range(12));
         end
         if (i == count / 2) drain_responses();
         pick = $urandom_range(999);
         if (pick < 600) cmd = CMD_VOTE;
         else if (pick < 960) cmd = CMD_READ;
         else if (pick < 997 || clears > 0) cmd = CMD_NOP;
         else cmd = CMD_CLEAR;
         if (cmd == CMD_CLEAR) clears++;
         send_request(cmd, random_request(cmd));
      end
   endtask

   initial begin
      model_cfg.grid_cols = 256;
      model_cfg.grid_rows = 256;
      model_cfg.radius_min = 10;
      model_cfg.radius_max = 100;
      model_cfg.inv_scale_q10 = 1024;
      model_cfg.peak_threshold = 100;
      foreach (vote_counts[i]) vote_counts[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_saturation();
      test_config_extremes();
      test_random(0, 0, 250);
      test_random(78, 0, 250);
      test_random(0, 78, 250);
      test_random(14, 14, 250);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("hough_circle_gradient_voter regression: pass");
      else
         $display("hough_circle_gradient_voter regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/hcgv_pkg.sv
rtl/core/hcgv_datapath.sv
rtl/core/hcgv_ctrl.sv
rtl/core/hough_circle_gradient_voter.sv
rtl/core/hcgv_checker.sv
sim/tb_hough_circle_gradient_voter.sv
